// ===== hw/rtl/bitmap_glyph_text_layout_core_assert.svh =====
// Shared assertion macros for the text layout core.
`ifndef BITMAP_GLYPH_TEXT_LAYOUT_CORE_ASSERT_SVH
`define BITMAP_GLYPH_TEXT_LAYOUT_CORE_ASSERT_SVH

// Checked while reset is released.
`define BGTL_ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bitmap_glyph_text_layout_core: assertion failed");

// Checked on every edge, reset included.
`define BGTL_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bitmap_glyph_text_layout_core: reset assertion failed");

`endif

// ===== hw/rtl/bgtl_pkg.sv =====
`default_nettype none

package bgtl_pkg;

    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 88;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    localparam logic [1:0] FUNC_BEGIN_TEXT = 2'd0;
    localparam logic [1:0] FUNC_CHAR       = 2'd1;
    localparam logic [1:0] FUNC_BEGIN_SCAN = 2'd2;
    localparam logic [1:0] FUNC_SCAN_PIXEL = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_HEIGHT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_SPACING   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LETTER_SPACING = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_WIDTH     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_HEIGHT    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_ROW     = 3'd5;

    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_SPACE     = 8'd32;
    localparam logic [7:0] CHAR_FIRST     = 8'd33;
    localparam logic [7:0] CHAR_LAST      = 8'd126;
    localparam logic [7:0] CHAR_EXT_FIRST = 8'd161;
    localparam logic [7:0] EXT_OFFSET     = 8'd34;

    typedef struct packed {
        logic [11:0] start;
        logic [11:0] width;
    } glyph_entry_t;

    typedef struct packed {
        logic [15:0] dst_y;
        logic [15:0] dst_x;
        logic [11:0] blit_height;
        logic [11:0] blit_width;
        logic [12:0] src_y;
        logic [11:0] src_x;
    } blit_t;

    // Table slot of a character; space reads slot 0 for its width.
    function automatic logic [7:0] glyph_index(input logic [7:0] code);
        logic [7:0] idx;
        idx = code - CHAR_FIRST;
        if (code == CHAR_SPACE) begin
            idx = 8'd0;
        end else if (code >= CHAR_EXT_FIRST) begin
            idx = idx - EXT_OFFSET;
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bgtl_glyph_table.sv =====
`default_nettype none

module bgtl_glyph_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   rd_en,
    input  wire logic [AW-1:0]          rd_addr,
    output bgtl_pkg::glyph_entry_t      rd_entry,
    input  wire logic                   wr_en,
    input  wire logic [AW-1:0]          wr_addr,
    input  wire bgtl_pkg::glyph_entry_t wr_entry
);

    logic [11:0] start_mem [DEPTH];
    logic [11:0] width_mem [DEPTH];

    bgtl_pkg::glyph_entry_t rd_data_reg;
    bgtl_pkg::glyph_entry_t fwd_entry_reg;
    logic                   fwd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            start_mem[wr_addr] <= wr_entry.start;
            width_mem[wr_addr] <= wr_entry.width;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg.start <= start_mem[rd_addr];
            rd_data_reg.width <= width_mem[rd_addr];
            fwd_entry_reg     <= wr_entry;
        end
    end

    // write landing on the slot being read in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_entry = fwd_hit_reg ? fwd_entry_reg : rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bgtl_out_skid.sv =====
`default_nettype none

module bgtl_out_skid (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire bgtl_pkg::blit_t  in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output bgtl_pkg::blit_t       out_data
);

    logic            out_valid_reg;
    logic            out_valid_next;
    logic            skid_valid_reg;
    logic            skid_valid_next;
    logic            load_out;
    logic            load_skid;
    bgtl_pkg::blit_t out_data_reg;
    bgtl_pkg::blit_t skid_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg) begin
            if (out_ready) begin
                skid_valid_next = 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || out_ready) begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end else begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg && out_ready) begin
            out_data_reg <= skid_data_reg;
        end else if (load_out) begin
            out_data_reg <= in_data;
        end
        if (load_skid) begin
            skid_data_reg <= in_data;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_glyph_text_layout_core.sv =====
// Path: a blit command is registered in stage 1, then in the output register (or its
// skid slot) before it shows on m_tdata.
// Throughput: one item per cycle; the pen update reads the glyph table once and
// closes its loop on the registered read port, with write forwarding.
// The input stalls only while the output register and its skid slot are both full.
// Reset (aresetn low, synchronous) clears pen, scan state, registers and entry count.
`default_nettype none

module bitmap_glyph_text_layout_core #(
    parameter int TABLE_DEPTH     = 256,
    parameter int STRIP_WIDTH_MAX = 4096
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // char_code[7:0], start_x[23:8], start_y[39:24], is_marker[40], zero pad
    input  wire logic [bgtl_pkg::S_TDATA_W-1:0]      s_tdata,
    // func[1:0]
    input  wire logic [1:0]                          s_tuser,
    // row_end
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // src_x[11:0], src_y[24:12], blit_width[36:25], blit_height[48:37],
    // dst_x[64:49], dst_y[80:65], zero pad
    output logic [bgtl_pkg::M_TDATA_W-1:0]           m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bgtl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [bgtl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int COL_W = $clog2(STRIP_WIDTH_MAX);
    localparam int SW    = (COL_W + 1 > 12) ? COL_W + 1 : 12;

    logic [11:0] glyph_height_reg;
    logic [11:0] line_spacing_reg;
    logic [11:0] letter_spacing_reg;
    logic [11:0] dest_width_reg;
    logic [11:0] dest_height_reg;
    logic [12:0] source_row_reg;

    logic        s_accept;
    logic        s1_go;
    logic        skid_ready;
    logic [AW-1:0] rd_addr;

    logic          s1_valid_reg;
    logic [1:0]    s1_func_reg;
    logic [7:0]    s1_code_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [15:0]   s1_start_x_reg;
    logic [15:0]   s1_start_y_reg;
    logic          s1_marker_reg;
    logic          s1_last_reg;

    logic [15:0]      pen_x_reg, pen_x_next;
    logic [15:0]      pen_y_reg, pen_y_next;
    logic [15:0]      line_start_x_reg, line_start_x_next;
    logic [COL_W-1:0] scan_column_reg, scan_column_next;
    logic             scan_in_run_reg, scan_in_run_next;
    logic [COL_W-1:0] scan_run_start_reg, scan_run_start_next;
    logic [CNT_W-1:0] scan_entry_count_reg, scan_entry_count_next;

    bgtl_pkg::glyph_entry_t tbl_entry;
    bgtl_pkg::glyph_entry_t wr_entry;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;

    logic             entry_valid;
    logic [11:0]      glyph_sx;
    logic [11:0]      glyph_w;
    logic [15:0]      lsp_ext;
    logic             printable;
    logic             on_surface;
    logic             close_run;
    logic             table_room;
    logic [COL_W-1:0] run_begin;
    logic [SW-1:0]    run_begin_ext;
    logic [SW-1:0]    end_col;
    logic [SW-1:0]    run_width;

    logic            res_valid;
    bgtl_pkg::blit_t res_data;
    bgtl_pkg::blit_t out_data;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_height_reg   <= '0;
            line_spacing_reg   <= '0;
            letter_spacing_reg <= '0;
            dest_width_reg     <= '0;
            dest_height_reg    <= '0;
            source_row_reg     <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bgtl_pkg::REG_GLYPH_HEIGHT:   glyph_height_reg   <= cfg_data[11:0];
                bgtl_pkg::REG_LINE_SPACING:   line_spacing_reg   <= cfg_data[11:0];
                bgtl_pkg::REG_LETTER_SPACING: letter_spacing_reg <= cfg_data[11:0];
                bgtl_pkg::REG_DEST_WIDTH:     dest_width_reg     <= cfg_data[11:0];
                bgtl_pkg::REG_DEST_HEIGHT:    dest_height_reg    <= cfg_data[11:0];
                bgtl_pkg::REG_SOURCE_ROW:     source_row_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: accept, issue table read
    assign s1_go    = s1_valid_reg && skid_ready;
    assign s_tready = !s1_valid_reg || s1_go;
    assign s_accept = s_tvalid && s_tready;
    assign rd_addr  = AW'(bgtl_pkg::glyph_index(s_tdata[7:0]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_func_reg    <= s_tuser;
            s1_code_reg    <= s_tdata[7:0];
            s1_addr_reg    <= rd_addr;
            s1_start_x_reg <= s_tdata[23:8];
            s1_start_y_reg <= s_tdata[39:24];
            s1_marker_reg  <= s_tdata[40];
            s1_last_reg    <= s_tlast;
        end
    end

    bgtl_glyph_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_accept),
        .rd_addr  (rd_addr),
        .rd_entry (tbl_entry),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry)
    );

    // stage 1: execute against pen and scan state
    assign entry_valid = CNT_W'(s1_addr_reg) < scan_entry_count_reg;
    assign glyph_sx    = entry_valid ? tbl_entry.start : 12'd0;
    assign glyph_w     = entry_valid ? tbl_entry.width : 12'd0;
    assign lsp_ext     = {{4{letter_spacing_reg[11]}}, letter_spacing_reg};

    assign printable = ((s1_code_reg >= bgtl_pkg::CHAR_FIRST) &&
                        (s1_code_reg <= bgtl_pkg::CHAR_LAST)) ||
                       (s1_code_reg >= bgtl_pkg::CHAR_EXT_FIRST);
    assign on_surface = (pen_x_reg[15] || (pen_x_reg < {4'd0, dest_width_reg})) &&
                        (pen_y_reg[15] || (pen_y_reg < {4'd0, dest_height_reg}));

    assign run_begin  = scan_in_run_reg ? scan_run_start_reg : scan_column_reg;
    assign close_run  = (scan_column_reg != '0) &&
                        ((!s1_marker_reg && s1_last_reg) ||
                         (s1_marker_reg && scan_in_run_reg));
    assign table_room = scan_entry_count_reg < CNT_W'(TABLE_DEPTH);
    assign run_begin_ext = SW'(run_begin);
    assign end_col    = SW'(scan_column_reg) + SW'(!s1_marker_reg && s1_last_reg);
    assign run_width  = end_col - run_begin_ext;

    assign wr_addr        = scan_entry_count_reg[AW-1:0];
    assign wr_entry.start = run_begin_ext[11:0];
    assign wr_entry.width = run_width[11:0];

    always_comb begin
        pen_x_next            = pen_x_reg;
        pen_y_next            = pen_y_reg;
        line_start_x_next     = line_start_x_reg;
        scan_column_next      = scan_column_reg;
        scan_in_run_next      = scan_in_run_reg;
        scan_run_start_next   = scan_run_start_reg;
        scan_entry_count_next = scan_entry_count_reg;
        wr_en                 = 1'b0;
        res_valid             = 1'b0;
        unique case (s1_func_reg)
            bgtl_pkg::FUNC_BEGIN_TEXT: begin
                pen_x_next        = s1_start_x_reg;
                line_start_x_next = s1_start_x_reg;
                pen_y_next        = s1_start_y_reg;
            end
            bgtl_pkg::FUNC_BEGIN_SCAN: begin
                scan_column_next      = '0;
                scan_in_run_next      = 1'b0;
                scan_run_start_next   = '0;
                scan_entry_count_next = '0;
            end
            bgtl_pkg::FUNC_SCAN_PIXEL: begin
                if (scan_column_reg != '0) begin
                    if (!s1_marker_reg) begin
                        scan_run_start_next = run_begin;
                        scan_in_run_next    = !s1_last_reg;
                    end else begin
                        scan_in_run_next = 1'b0;
                    end
                end
                if (close_run && table_room) begin
                    wr_en                 = s1_go;
                    scan_entry_count_next = scan_entry_count_reg + CNT_W'(1);
                end
                if (scan_column_reg != COL_W'(STRIP_WIDTH_MAX - 1)) begin
                    scan_column_next = scan_column_reg + COL_W'(1);
                end
            end
            bgtl_pkg::FUNC_CHAR: begin
                if (s1_code_reg == bgtl_pkg::CHAR_NEWLINE) begin
                    pen_x_next = line_start_x_reg;
                    pen_y_next = pen_y_reg + {4'd0, glyph_height_reg} +
                                 {{4{line_spacing_reg[11]}}, line_spacing_reg};
                end else if (s1_code_reg == bgtl_pkg::CHAR_SPACE) begin
                    pen_x_next = pen_x_reg + {4'd0, glyph_w} + lsp_ext;
                end else if (printable && on_surface) begin
                    res_valid  = s1_go;
                    pen_x_next = pen_x_reg + {4'd0, glyph_w} + lsp_ext;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg            <= '0;
            pen_y_reg            <= '0;
            line_start_x_reg     <= '0;
            scan_column_reg      <= '0;
            scan_in_run_reg      <= 1'b0;
            scan_run_start_reg   <= '0;
            scan_entry_count_reg <= '0;
        end else if (s1_go) begin
            pen_x_reg            <= pen_x_next;
            pen_y_reg            <= pen_y_next;
            line_start_x_reg     <= line_start_x_next;
            scan_column_reg      <= scan_column_next;
            scan_in_run_reg      <= scan_in_run_next;
            scan_run_start_reg   <= scan_run_start_next;
            scan_entry_count_reg <= scan_entry_count_next;
        end
    end

    assign res_data.src_x       = glyph_sx;
    assign res_data.src_y       = source_row_reg;
    assign res_data.blit_width  = glyph_w;
    assign res_data.blit_height = glyph_height_reg;
    assign res_data.dst_x       = pen_x_reg;
    assign res_data.dst_y       = pen_y_reg;

    bgtl_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (skid_ready),
        .in_data   (res_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {7'd0, out_data.dst_y, out_data.dst_x, out_data.blit_height,
                      out_data.blit_width, out_data.src_y, out_data.src_x};

endmodule

`default_nettype wire

// ===== hw/rtl/bgtl_checker.sv =====
`default_nettype none

`include "bitmap_glyph_text_layout_core_assert.svh"

module bgtl_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [bgtl_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled result keeps its transaction intact
    `BGTL_ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // reset empties the pipe and opens the input
    `BGTL_ASSERT_ALWAYS(a_reset_state, aclk, !aresetn |=> s_tready && !m_tvalid)

    // m_tvalid cannot rise without an input transaction accepted ahead of it
    `BGTL_ASSERT_CLK(a_no_orphan, aclk, aresetn, !(s_tvalid && s_tready) ##1 !m_tvalid |=> !m_tvalid)

endmodule

bind bitmap_glyph_text_layout_core bgtl_checker u_bgtl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;

    localparam int GLYPH_SLOTS  = 256;
    localparam int STRIP_MAX    = 4096;
    localparam int TAIL_CYCLES  = 8;
    localparam int DRAIN_LIMIT  = 20000;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  code;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic        marker;
        logic        row_end;
    } item_t;

    logic                                    aclk = 1'b0;
    logic                                    aresetn = 1'b0;
    logic                                    s_tvalid = 1'b0;
    wire logic                               s_tready;
    logic [bgtl_pkg::S_TDATA_W-1:0]          s_tdata = '0;
    logic [1:0]                              s_tuser = '0;
    logic                                    s_tlast = 1'b0;
    wire logic                               m_tvalid;
    logic                                    m_tready = 1'b0;
    wire logic [bgtl_pkg::M_TDATA_W-1:0]     m_tdata;
    logic                                    cfg_valid = 1'b0;
    wire logic                               cfg_ready;
    logic [bgtl_pkg::CFG_INDEX_W-1:0]        cfg_index = '0;
    logic [bgtl_pkg::CFG_DATA_W-1:0]         cfg_data = '0;

    bitmap_glyph_text_layout_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // layout predictor state
    logic [11:0] glyph_h, line_gap, letter_gap, dest_w, dest_h;
    logic [12:0] src_row;
    logic [11:0] start_tab [GLYPH_SLOTS];
    logic [11:0] width_tab [GLYPH_SLOTS];
    logic [15:0] pen_x, pen_y, line_x;
    int          scan_col;
    bit          in_run;
    int          run_start;
    int          n_entries;

    bgtl_pkg::blit_t blits_due[$];
    int    bad_blits = 0;
    int    items_sent = 0;
    int    tx_gap_top = 17;
    int    tx_calm = 0;
    int    rx_calm = 0;
    int    rx_hold = 0;

    function automatic int sx12(logic [11:0] v);
        return int'($signed(v));
    endfunction

    function automatic void clear_strip();
        for (int i = 0; i < GLYPH_SLOTS; i++) begin
            start_tab[i] = '0;
            width_tab[i] = '0;
        end
        scan_col = 0;
        in_run = 1'b0;
        run_start = 0;
        n_entries = 0;
    endfunction

    function automatic void reset_layout();
        glyph_h = '0;
        line_gap = '0;
        letter_gap = '0;
        dest_w = '0;
        dest_h = '0;
        src_row = '0;
        pen_x = '0;
        pen_y = '0;
        line_x = '0;
        clear_strip();
    endfunction

    function automatic void record_run(int end_col);
        if (n_entries < GLYPH_SLOTS) begin
            start_tab[n_entries] = 12'(run_start);
            width_tab[n_entries] = 12'(end_col - run_start);
            n_entries++;
        end
        in_run = 1'b0;
    endfunction

    function automatic void layout_step(item_t it);
        int              idx;
        bit              printable;
        bgtl_pkg::blit_t b;
        case (it.func)
            bgtl_pkg::FUNC_BEGIN_TEXT: begin
                pen_x = it.start_x;
                line_x = it.start_x;
                pen_y = it.start_y;
            end
            bgtl_pkg::FUNC_BEGIN_SCAN: begin
                clear_strip();
            end
            bgtl_pkg::FUNC_SCAN_PIXEL: begin
                if (scan_col != 0) begin
                    if (!it.marker) begin
                        if (!in_run) begin
                            in_run = 1'b1;
                            run_start = scan_col;
                        end
                        if (it.row_end)
                            record_run(scan_col + 1);
                    end else if (in_run) begin
                        record_run(scan_col);
                    end
                end
                if (scan_col < STRIP_MAX - 1)
                    scan_col++;
            end
            default: begin
                printable = it.code >= bgtl_pkg::CHAR_FIRST &&
                            (it.code <= bgtl_pkg::CHAR_LAST ||
                             it.code >= bgtl_pkg::CHAR_EXT_FIRST);
                if (it.code == bgtl_pkg::CHAR_NEWLINE) begin
                    pen_x = line_x;
                    pen_y = 16'(int'(pen_y) + int'(glyph_h) + sx12(line_gap));
                end else if (it.code == bgtl_pkg::CHAR_SPACE) begin
                    pen_x = 16'(int'(pen_x) + int'(width_tab[0]) + sx12(letter_gap));
                end else if (printable && int'($signed(pen_x)) < int'(dest_w) &&
                             int'($signed(pen_y)) < int'(dest_h)) begin
                    idx = int'(it.code) - int'(bgtl_pkg::CHAR_FIRST);
                    if (it.code >= bgtl_pkg::CHAR_EXT_FIRST)
                        idx -= int'(bgtl_pkg::EXT_OFFSET);
                    b.src_x = start_tab[idx];
                    b.src_y = src_row;
                    b.blit_width = width_tab[idx];
                    b.blit_height = glyph_h;
                    b.dst_x = pen_x;
                    b.dst_y = pen_y;
                    blits_due = {blits_due, b};
                    pen_x = 16'(int'(pen_x) + int'(width_tab[idx]) + sx12(letter_gap));
                end
            end
        endcase
    endfunction

    function automatic int pick_gap(inout int calm_left, input int top);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, top);
    endfunction

    function automatic item_t noise_item();
        item_t it;
        it.func = 2'($urandom);
        it.code = 8'($urandom);
        it.start_x = 16'($urandom);
        it.start_y = 16'($urandom);
        it.marker = 1'($urandom);
        it.row_end = 1'($urandom);
        return it;
    endfunction

    function automatic item_t mk_text(int x, int y);
        item_t it;
        it = noise_item();
        it.func = bgtl_pkg::FUNC_BEGIN_TEXT;
        it.start_x = 16'(x);
        it.start_y = 16'(y);
        return it;
    endfunction

    function automatic item_t mk_char(int code);
        item_t it;
        it = noise_item();
        it.func = bgtl_pkg::FUNC_CHAR;
        it.code = 8'(code);
        return it;
    endfunction

    function automatic item_t mk_scan();
        item_t it;
        it = noise_item();
        it.func = bgtl_pkg::FUNC_BEGIN_SCAN;
        return it;
    endfunction

    function automatic item_t mk_pixel(bit m, bit last);
        item_t it;
        it = noise_item();
        it.func = bgtl_pkg::FUNC_SCAN_PIXEL;
        it.marker = m;
        it.row_end = last;
        return it;
    endfunction

    function automatic int glyph_code();
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(int'(bgtl_pkg::CHAR_EXT_FIRST), 255);
        return $urandom_range(int'(bgtl_pkg::CHAR_FIRST), int'(bgtl_pkg::CHAR_LAST));
    endfunction

    function automatic item_t text_start_item();
        if ($urandom_range(0, 7) == 0)
            return mk_text($urandom, $urandom);
        return mk_text(-40 + int'($urandom_range(0, int'(dest_w) + 60)),
                       -40 + int'($urandom_range(0, int'(dest_h) + 60)));
    endfunction

    function automatic item_t random_text_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return mk_char(glyph_code());
        if (r < 78)
            return mk_char(bgtl_pkg::CHAR_NEWLINE);
        if (r < 86)
            return mk_char(bgtl_pkg::CHAR_SPACE);
        if (r < 91)
            return mk_char($urandom_range(0, 1) ? $urandom_range(0, 31)
                                                : $urandom_range(127, 160));
        if (r < 96)
            return text_start_item();
        return noise_item();
    endfunction

    function automatic logic [11:0] spread12(int lo, int hi, int ext_lo, int ext_hi);
        int r;
        r = $urandom_range(0, 11);
        if (r == 0)
            return 12'(ext_lo);
        if (r == 1)
            return 12'(ext_hi);
        if (r == 2)
            return 12'($urandom);
        return 12'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    task automatic send_item(item_t it);
        int gap;
        gap = pick_gap(tx_calm, tx_gap_top);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {7'd0, it.marker, it.start_y, it.start_x, it.code};
        s_tuser = it.func;
        s_tlast = it.row_end;
        do @(posedge aclk); while (!s_tready);
        layout_step(it);
        items_sent++;
    endtask

    task automatic drain_blits();
        int guard;
        guard = 0;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (blits_due.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [bgtl_pkg::CFG_INDEX_W-1:0] idx,
                             logic [bgtl_pkg::CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            bgtl_pkg::REG_GLYPH_HEIGHT:   glyph_h = value[11:0];
            bgtl_pkg::REG_LINE_SPACING:   line_gap = value[11:0];
            bgtl_pkg::REG_LETTER_SPACING: letter_gap = value[11:0];
            bgtl_pkg::REG_DEST_WIDTH:     dest_w = value[11:0];
            bgtl_pkg::REG_DEST_HEIGHT:    dest_h = value[11:0];
            bgtl_pkg::REG_SOURCE_ROW:     src_row = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // upper data bit is don't-care for the 12-bit registers
    task automatic set_layout(logic [11:0] h, logic [11:0] line, logic [11:0] letter,
                              logic [11:0] dw, logic [11:0] dh, logic [12:0] src);
        drain_blits();
        write_reg(bgtl_pkg::REG_GLYPH_HEIGHT, {1'($urandom), h});
        write_reg(bgtl_pkg::REG_LINE_SPACING, {1'($urandom), line});
        write_reg(bgtl_pkg::REG_LETTER_SPACING, {1'($urandom), letter});
        write_reg(bgtl_pkg::REG_DEST_WIDTH, {1'($urandom), dw});
        write_reg(bgtl_pkg::REG_DEST_HEIGHT, {1'($urandom), dh});
        write_reg(bgtl_pkg::REG_SOURCE_ROW, src);
    endtask

    task automatic check_blit(bgtl_pkg::blit_t got);
        bgtl_pkg::blit_t want;
        if (blits_due.size() == 0) begin
            bad_blits++;
            if (bad_blits <= 10)
                $display("unexpected blit transaction: %h", got);
        end else begin
            want = blits_due.pop_front();
            if (got.src_x !== want.src_x || got.src_y !== want.src_y ||
                got.blit_width !== want.blit_width ||
                got.blit_height !== want.blit_height ||
                got.dst_x !== want.dst_x || got.dst_y !== want.dst_y) begin
                bad_blits++;
                if (bad_blits <= 10) begin
                    $display("blit mismatch: exp src=(%0d,%0d) %0dx%0d dst=(%0d,%0d)",
                             want.src_x, $signed(want.src_y), want.blit_width,
                             want.blit_height, $signed(want.dst_x), $signed(want.dst_y));
                    $display("               got src=(%0d,%0d) %0dx%0d dst=(%0d,%0d)",
                             got.src_x, $signed(got.src_y), got.blit_width,
                             got.blit_height, $signed(got.dst_x), $signed(got.dst_y));
                end
            end
        end
    endtask

    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = pick_gap(rx_calm, 17);
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                repeat (rx_hold) @(negedge aclk);
                rx_hold = 0;
            end
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            check_blit(bgtl_pkg::blit_t'(m_tdata[$bits(bgtl_pkg::blit_t)-1:0]));
        end
    end

    // registers still at reset: zero-size surface, only negative pens draw
    task automatic test_power_on();
        send_item(mk_text(-3, -7));
        send_item(mk_char(bgtl_pkg::CHAR_FIRST));
        send_item(mk_char(bgtl_pkg::CHAR_NEWLINE));
        send_item(mk_char(bgtl_pkg::CHAR_SPACE));
        send_item(mk_char(255));
        send_item(mk_text(0, 0));
        send_item(mk_char(65));
    endtask

    task automatic test_scan_rules();
        int codes[11] = '{33, 34, 35, 32, 10, 126, 161, 127, 160, 31, 0};
        set_layout(12'd16, 12'd2, 12'd1, 12'd4095, 12'd4095, 13'd100);
        send_item(mk_scan());
        send_item(mk_pixel(1'b0, 1'b0));
        send_item(mk_pixel(1'b0, 1'b0));
        send_item(mk_pixel(1'b1, 1'b0));
        send_item(mk_pixel(1'b0, 1'b1));
        // pixels past the row end keep scanning
        send_item(mk_pixel(1'b0, 1'b0));
        send_item(mk_pixel(1'b0, 1'b0));
        send_item(mk_pixel(1'b1, 1'b0));
        send_item(mk_pixel(1'b1, 1'b0));
        send_item(mk_text(5, 3));
        foreach (codes[i])
            send_item(mk_char(codes[i]));
    endtask

    task automatic test_extremes();
        set_layout(12'd4095, 12'h7FF, 12'h7FF, 12'd4095, 12'd4095, 13'h0FFF);
        send_item(mk_text(-32768, -32768));
        send_item(mk_char(33));
        send_item(mk_char(bgtl_pkg::CHAR_NEWLINE));
        send_item(mk_char(35));
        set_layout(12'd0, 12'h800, 12'h800, 12'd0, 12'd0, 13'h1000);
        send_item(mk_text(-1, -1));
        send_item(mk_char(33));
        send_item(mk_char(bgtl_pkg::CHAR_SPACE));
        send_item(mk_char(255));
        send_item(mk_char(0));
        send_item(mk_text(32767, -32768));
        send_item(mk_char(33));
        send_item(mk_char(bgtl_pkg::CHAR_NEWLINE));
        send_item(mk_char(126));
    endtask

    task automatic test_table_full();
        set_layout(12'd9, 12'd0, 12'd0, 12'd4095, 12'd4095, 13'd40);
        send_item(mk_scan());
        send_item(mk_pixel(1'b0, 1'b0));
        repeat (GLYPH_SLOTS + 14) begin
            send_item(mk_pixel(1'b0, 1'b0));
            send_item(mk_pixel(1'b1, 1'b0));
        end
        send_item(mk_text(0, 0));
        send_item(mk_char(bgtl_pkg::CHAR_SPACE));
        send_item(mk_char(33));
        repeat (40) send_item(mk_char(glyph_code()));
    endtask

    task automatic test_backpressure();
        set_layout(12'd8, 12'd0, 12'd1, 12'd4095, 12'd4095, 13'd7);
        send_item(mk_text(0, 0));
        rx_hold = 300;
        tx_gap_top = 0;
        repeat (60) send_item(mk_char(glyph_code()));
        tx_gap_top = 17;
        drain_blits();
        repeat (10) send_item(mk_char(glyph_code()));
    endtask

    task automatic random_strip();
        int  runs;
        int  len;
        bit  edge_close;
        send_item(mk_scan());
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(10, 60))
                send_item(mk_pixel(1'($urandom), 1'($urandom)));
        end else begin
            send_item(mk_pixel(1'($urandom), 1'b0));
            runs = $urandom_range(3, 16);
            edge_close = 1'($urandom);
            for (int r = 0; r < runs; r++) begin
                len = $urandom_range(1, 10);
                for (int c = 0; c < len; c++)
                    send_item(mk_pixel(1'b0, edge_close && r == runs - 1 && c == len - 1));
                if (!(edge_close && r == runs - 1))
                    repeat ($urandom_range(1, 3)) send_item(mk_pixel(1'b1, 1'b0));
            end
        end
    endtask

    task automatic random_text(int count, bit pause);
        send_item(text_start_item());
        for (int k = 0; k < count; k++) begin
            if (pause && k == count / 2)
                drain_blits();
            send_item(random_text_item());
        end
    endtask

    task automatic test_random();
        int first;
        first = items_sent;
        while (items_sent - first < 600) begin
            set_layout(spread12(1, 40, 0, 4095), spread12(-6, 10, -2048, 2047),
                       spread12(-3, 6, -2048, 2047), spread12(100, 4095, 0, 4095),
                       spread12(100, 4095, 0, 4095), 13'($urandom));
            random_strip();
            random_text($urandom_range(30, 90), $urandom_range(0, 3) == 0);
        end
    endtask

    initial begin
        reset_layout();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_power_on();
        test_scan_rules();
        test_extremes();
        test_table_full();
        test_backpressure();
        test_random();

        drain_blits();
        bad_blits += blits_due.size();
        if (bad_blits == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
